// ===== hdl/gmt_pkg.sv =====
`timescale 1ns / 1ps

package gmt_pkg;

  // register map of the configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_EDGE_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_USE_SOBEL      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH    = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd3;

  localparam int ROW_W     = 16;
  localparam int OUT_COL_W = 11;
  localparam int GRAD_W    = 11;  // holds +-1020 and 2*255

  typedef logic [7:0]           pixel_t;
  typedef logic [ROW_W-1:0]     row_t;
  typedef logic [OUT_COL_W-1:0] out_col_t;

  // one target pixel after the gradient step
  typedef struct packed {
    logic signed [GRAD_W-1:0] grad_a;
    logic signed [GRAD_W-1:0] grad_b;
    logic                     zero_mag;
    row_t                     row;
    out_col_t                 col;
    logic                     last;
  } grad_t;

endpackage

// ===== hdl/gmt_line_ram.sv =====
`timescale 1ns / 1ps

module gmt_line_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read-first on a same-address collision
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/gradient_magnitude_threshold_unit.sv =====
`timescale 1ns / 1ps

// Channel   Handshake             Payload
// -------   -------------------   ---------------------------------------------
// in        in_valid / in_ready   gray_pixel, raster order
// out       out_valid/ out_ready  edge_mark, out_row, out_col, last_of_run
// cfg       cfg_we (no wait)      cfg_index, cfg_data
//
// One pixel request is taken per clock while the window has at most one result
// left and can send it; most pixels yield at most one result, a pixel that closes
// a row or lies in the last row two, the last of the frame four. The output drains
// one result per clock while out_ready is high. A result passes the fetch,
// window, gradient and compare stages, the last being the output register.
// Reset is synchronous; the line stores need no clearing pass, so in_ready
// is high in the first cycle after reset. Output stalls back up stage by
// stage; every stage holds its contents until the next one can take them.

module gradient_magnitude_threshold_unit #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                             clk,
  input  logic                             rst,
  // pixel input
  input  logic                             in_valid,
  output logic                             in_ready,
  input  gmt_pkg::pixel_t                  gray_pixel,
  // result output
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             edge_mark,
  output gmt_pkg::row_t                    out_row,
  output gmt_pkg::out_col_t                out_col,
  output logic                             last_of_run,
  // configuration writes
  input  logic                             cfg_we,
  input  logic [gmt_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [gmt_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import gmt_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);      // column index
  localparam int WW = $clog2(MAX_WIDTH + 1);  // column count up to MAX_WIDTH

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [9:0]  edge_threshold;
  logic        use_sobel;
  logic [11:0] image_width;
  logic [15:0] image_height;
  logic [19:0] thr_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_threshold <= 10'd25;
      use_sobel      <= 1'b0;
      image_width    <= 12'd640;
      image_height   <= 16'd480;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EDGE_THRESHOLD: edge_threshold <= cfg_data[9:0];
        CFG_USE_SOBEL:      use_sobel      <= cfg_data[0];
        CFG_IMAGE_WIDTH:    image_width    <= cfg_data[11:0];
        CFG_IMAGE_HEIGHT:   image_height   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // squared threshold, refreshed every cycle (the user must move config only while idle; the block does not enforce it)
  always_ff @(posedge clk) begin
    thr_sq <= edge_threshold * edge_threshold;
  end

  // effective frame size: width clamped to 1..MAX_WIDTH, height at least 1
  logic [WW-1:0] w_eff;
  row_t          h_eff;

  always_comb begin
    priority if (image_width == '0) begin
      w_eff = WW'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(image_width);
    end
    h_eff = (image_height == '0) ? row_t'(1) : image_height;
  end

  // ---------------------------------------------------------------------------
  // raster position of the incoming pixel
  // ---------------------------------------------------------------------------
  logic [CW-1:0] col_count, col_count_next;
  row_t          row_count, row_count_next;
  logic [CW-1:0] cur_c;
  row_t          cur_r;
  logic [3:0]    cur_mask;
  logic          accept;

  assign accept = in_valid && in_ready;

  always_comb begin
    logic          col_wrap;
    logic [16:0]   row_a;
    logic [16:0]   row_b;
    logic [WW-1:0] col_b;
    logic          last_row;
    logic          last_col;

    // a position left outside the frame by a geometry change folds back in
    col_wrap = WW'(col_count) >= w_eff;
    cur_c    = col_wrap ? '0 : col_count;
    row_a    = col_wrap ? 17'(row_count) + 17'd1 : 17'(row_count);
    cur_r    = (row_a >= 17'(h_eff)) ? '0 : row_a[15:0];

    col_b = WW'(cur_c) + WW'(1);
    row_b = 17'(cur_r) + 17'd1;
    if (col_b >= w_eff) begin
      col_count_next = '0;
      row_count_next = (row_b >= 17'(h_eff)) ? '0 : row_b[15:0];
    end else begin
      col_count_next = CW'(col_b);
      row_count_next = cur_r;
    end

    // targets up-left, up, left, self; a pixel goes out once its last
    // neighbour (clamped to the frame) has arrived
    last_row    = cur_r == h_eff - row_t'(1);
    last_col    = WW'(cur_c) == w_eff - WW'(1);
    cur_mask[0] = (cur_r != '0) && (cur_c != '0);
    cur_mask[1] = (cur_r != '0) && last_col;
    cur_mask[2] = last_row && (cur_c != '0);
    cur_mask[3] = last_row && last_col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // ---------------------------------------------------------------------------
  // fetch stage: line store read, {older, newer} per column
  // ---------------------------------------------------------------------------
  logic          fetch_valid;
  pixel_t        fetch_pix;
  row_t          fetch_row;
  logic [CW-1:0] fetch_col;
  logic [3:0]    fetch_mask;
  logic          byp_hit;
  logic [15:0]   byp_data;
  logic [15:0]   ram_rdata;
  logic [15:0]   line_q;
  logic [15:0]   line_wdata;
  logic          win_adv;

  // with a one-pixel row the next read hits the column being written
  assign line_q     = byp_hit ? byp_data : ram_rdata;
  assign line_wdata = {line_q[7:0], fetch_pix};
  assign in_ready   = !fetch_valid || win_adv;

  gmt_line_ram #(
    .WIDTH (16),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (win_adv),
    .waddr (fetch_col),
    .wdata (line_wdata),
    .re    (accept),
    .raddr (cur_c),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fetch_valid <= 1'b0;
      byp_hit     <= 1'b0;
    end else begin
      if (in_ready) begin
        fetch_valid <= in_valid;
      end
      if (accept) begin
        byp_hit <= win_adv && (fetch_col == cur_c);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fetch_pix  <= gray_pixel;
      fetch_row  <= cur_r;
      fetch_col  <= cur_c;
      fetch_mask <= cur_mask;
      byp_data   <= line_wdata;
    end
  end

  // ---------------------------------------------------------------------------
  // window stage: 3x3 window plus the targets still to send
  // ---------------------------------------------------------------------------
  pixel_t        win [9];
  row_t          win_row;
  logic [CW-1:0] win_col;
  logic [3:0]    win_mask;
  logic [1:0]    pick;
  logic [3:0]    rest;
  logic          emit;
  logic          grad_valid;
  logic          out_free;
  logic          grad_ready;

  assign out_free   = !out_valid || out_ready;
  assign grad_ready = !grad_valid || out_free;
  assign emit       = (win_mask != '0) && grad_ready;

  always_comb begin
    priority if (win_mask[0]) begin
      pick = 2'd0;
    end else if (win_mask[1]) begin
      pick = 2'd1;
    end else if (win_mask[2]) begin
      pick = 2'd2;
    end else begin
      pick = 2'd3;
    end
    rest = win_mask & ~(4'b0001 << pick);
  end

  assign win_adv = fetch_valid && ((win_mask == '0) || (emit && rest == '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      win_mask <= '0;
      for (int k = 0; k < 9; k++) begin
        win[k] <= '0;
      end
    end else if (win_adv) begin
      win_mask <= fetch_mask;
      for (int k = 0; k < 3; k++) begin
        win[k*3]   <= win[k*3+1];
        win[k*3+1] <= win[k*3+2];
      end
      win[2] <= line_q[15:8];
      win[5] <= line_q[7:0];
      win[8] <= fetch_pix;
    end else if (emit) begin
      win_mask <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (win_adv) begin
      win_row <= fetch_row;
      win_col <= fetch_col;
    end
  end

  // ---------------------------------------------------------------------------
  // gradient of the picked target
  // ---------------------------------------------------------------------------
  grad_t grad_next, grad;

  always_comb begin
    pixel_t                   ext [4][4];
    pixel_t                   nb  [3][3];
    row_t                     ti;
    logic [CW-1:0]            tj;
    logic                     inner_row;
    logic                     inner_col;
    logic signed [GRAD_W-1:0] s [3][3];
    logic signed [GRAD_W-1:0] dv, dh, p2, gx, gy;

    // window padded with zeros below and right of the newest pixel
    for (int a = 0; a < 4; a++) begin
      for (int b = 0; b < 4; b++) begin
        ext[a][b] = (a < 3 && b < 3) ? win[a*3+b] : '0;
      end
    end
    // 3x3 neighbourhood centered on the target
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        nb[a][b] = ext[2'(a) + {1'b0, pick[1]}][2'(b) + {1'b0, pick[0]}];
        s[a][b]  = $signed({3'b000, nb[a][b]});
      end
    end

    ti = win_row - row_t'(1) + row_t'(pick[1]);
    tj = win_col - CW'(1) + CW'(pick[0]);
    inner_row = (ti != '0) && (ti != h_eff - row_t'(1));
    inner_col = (tj != '0) && (WW'(tj) != w_eff - WW'(1));

    dv = s[2][1] - s[0][1];
    dh = s[1][2] - s[1][0];
    p2 = s[1][1] + s[1][1];
    gx = s[0][2] - s[0][0] + s[2][2] - s[2][0] + 2 * (s[1][2] - s[1][0]);
    gy = s[2][0] - s[0][0] + s[2][2] - s[0][2] + 2 * (s[2][1] - s[0][1]);

    // plain mode: border component is the pixel itself, doubled to match 4x scale
    if (use_sobel) begin
      grad_next.grad_a = gx;
      grad_next.grad_b = gy;
    end else begin
      grad_next.grad_a = inner_row ? dv : p2;
      grad_next.grad_b = inner_col ? dh : p2;
    end
    grad_next.zero_mag = use_sobel && !(inner_row && inner_col);
    grad_next.row      = ti;
    grad_next.col      = out_col_t'(tj);
    grad_next.last     = rest == '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grad_valid <= 1'b0;
    end else if (grad_ready) begin
      grad_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      grad <= grad_next;
    end
  end

  // ---------------------------------------------------------------------------
  // compare stage: a^2 + b^2 against 4*s^2 (plain) or 16*s^2 (Sobel)
  // ---------------------------------------------------------------------------
  logic signed [2*GRAD_W-1:0] sq_a, sq_b;
  logic [20:0]                mag;
  logic [23:0]                limit;

  assign sq_a  = grad.grad_a * grad.grad_a;
  assign sq_b  = grad.grad_b * grad.grad_b;
  assign mag   = {1'b0, sq_a[19:0]} + {1'b0, sq_b[19:0]};
  assign limit = use_sobel ? {thr_sq, 4'b0000} : {2'b00, thr_sq, 2'b00};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= grad_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && grad_valid) begin
      edge_mark   <= !grad.zero_mag && ({3'b000, mag} > limit);
      out_row     <= grad.row;
      out_col     <= grad.col;
      last_of_run <= grad.last;
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !grad_valid && !fetch_valid && (win_mask == '0))
    else $error("pipeline not empty after reset");

  a_emit_lands: assert property (@(posedge clk) disable iff (rst)
    emit |=> grad_valid)
    else $error("emitted target lost before the compare stage");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    fetch_valid && ($countones(win_mask) > 1) |-> !in_ready)
    else $error("pixel taken while window still has several targets");

endmodule
